// ===== rtl/modbus_rtu_slave_frame_engine_defines.svh =====
// Assertion macros for the checker file of the Modbus RTU slave frame engine.
// No dependencies.
`ifndef MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_FRAME_ENGINE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define MBRTU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("modbus rtu slave check failed");

// Property that must hold in the cycle after its antecedent.
`define MBRTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("modbus rtu slave check failed");

`endif

// ===== rtl/mbrtu_pkg.sv =====
// Package of the Modbus RTU slave frame engine: sizes, function codes and CRC types.
// No dependencies.
package mbrtu_pkg;

    localparam int REG_COUNT = 32;
    localparam int MAX_COUNT = 29;
    localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

    localparam logic ADDR_SLAVE_ID = 1'b0;
    localparam logic ADDR_REG_BASE = 1'b1;

    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } crc_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } crc_stat_t;

endpackage

// ===== rtl/modbus_rtu_slave_frame_engine.sv =====
// Modbus RTU slave frame engine: one received byte per input transaction, function
// codes 3, 4, 6 and 16, reply bytes with CRC on the output stream. The CRC runs bit
// serially, so each request byte that enters the CRC holds s_tready low until the CRC
// unit is idle again, and the final CRC byte of a good request holds it low until the
// last reply byte has been handed to the output register. Each reply byte before the
// CRC also waits for the CRC unit, register reads add a store read, and any output
// stall holds the reply. Function 6 and 16 end with a final write, and function 16
// first sweeps the store, committing each staged entry. Store entries read as zero
// until written after reset.
// Depends on mbrtu_pkg, mbrtu_crc and mbrtu_ram.
module modbus_rtu_slave_frame_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mbrtu_pkg::*;

    typedef enum logic [3:0] {
        P_ID, P_FUNC, P_ADDR_H, P_ADDR_L, P_CNT_H, P_CNT_L,
        P_CRC_H, P_CRC_L, P_BYTECNT, P_DATA_H, P_DATA_L
    } parse_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CRC_WAIT, S_COMMIT_RD, S_COMMIT_WR, S_LASTWR,
        S_TX_NEXT, S_RD_ISSUE, S_RD_DATA, S_TX_EMIT, S_TX_CRC
    } seq_t;

    parse_t parse_reg, parse_next;
    seq_t   seq_reg, seq_next;

    logic [7:0]           slave_id_reg, slave_id_next;
    logic [15:0]          reg_base_reg, reg_base_next;
    logic [7:0]           fc_reg, fc_next;
    logic [15:0]          start_address_reg, start_address_next;
    logic [15:0]          current_address_reg, current_address_next;
    logic [15:0]          point_count_reg, point_count_next;
    logic [4:0]           points_left_reg, points_left_next;
    logic [7:0]           crc_hi_reg, crc_hi_next;
    logic [15:0]          write_value_reg, write_value_next;
    logic [REG_COUNT-1:0] staged_valid_reg, staged_valid_next;
    logic [REG_COUNT-1:0] store_valid_reg, store_valid_next;
    logic [IDX_W-1:0]     cm_idx_reg, cm_idx_next;
    logic [5:0]           tx_idx_reg, tx_idx_next;
    logic [15:0]          rd_val_reg, rd_val_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_data_reg, m_data_next;
    logic                 m_last_reg, m_last_next;

    crc_cmd_t  crc_cmd;
    crc_stat_t crc_stat;

    logic             store_we, stage_we;
    logic [IDX_W-1:0] store_waddr, store_raddr, stage_waddr, stage_raddr;
    logic [15:0]      store_wdata, stage_wdata, store_q, stage_q;

    logic             accept, cfg_wr, out_free, is_rd, fc_ok;
    logic [15:0]      cur_off, rd_off, rd_addr;
    logic             cur_map, rd_map;
    logic [IDX_W-1:0] cur_idx, rd_idx;
    logic [5:0]       body_len, rd_pos;
    logic [7:0]       tx_sel;
    logic             tx_is_crc, tx_is_end;

    mbrtu_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (crc_cmd),
        .stat_o  (crc_stat)
    );

    mbrtu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_store (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .raddr (store_raddr),
        .rdata (store_q)
    );

    mbrtu_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_stage (
        .aclk  (aclk),
        .we    (stage_we),
        .waddr (stage_waddr),
        .wdata (stage_wdata),
        .raddr (stage_raddr),
        .rdata (stage_q)
    );

    assign s_tready = (seq_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ADDR_REG_BASE) ? {16'h0000, reg_base_reg}
                                                  : {24'h000000, slave_id_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign fc_ok = (s_tdata == FC_READ_HOLDING) || (s_tdata == FC_READ_INPUT) ||
                   (s_tdata == FC_WRITE_SINGLE) || (s_tdata == FC_WRITE_MULTI);
    assign is_rd = (fc_reg == FC_READ_HOLDING) || (fc_reg == FC_READ_INPUT);

    assign cur_off = current_address_reg - reg_base_reg;
    assign cur_map = cur_off < 16'(REG_COUNT);
    assign cur_idx = cur_off[IDX_W-1:0];

    assign body_len = is_rd ? (6'd3 + {point_count_reg[4:0], 1'b0}) : 6'd6;
    assign rd_pos   = tx_idx_reg - 6'd3;
    assign rd_addr  = start_address_reg + {11'd0, rd_pos[5:1]};
    assign rd_off   = rd_addr - reg_base_reg;
    assign rd_map   = rd_off < 16'(REG_COUNT);
    assign rd_idx   = rd_off[IDX_W-1:0];

    assign tx_is_crc = (tx_idx_reg == body_len) || (tx_idx_reg == body_len + 6'd1);
    assign tx_is_end = (tx_idx_reg == body_len + 6'd1);

    always_comb begin
        tx_sel = 8'h00;
        if (tx_idx_reg == body_len) begin
            tx_sel = crc_stat.crc[7:0];
        end else if (tx_is_end) begin
            tx_sel = crc_stat.crc[15:8];
        end else if (tx_idx_reg == 6'd0) begin
            tx_sel = slave_id_reg;
        end else if (tx_idx_reg == 6'd1) begin
            tx_sel = fc_reg;
        end else if (is_rd) begin
            if (tx_idx_reg == 6'd2) begin
                tx_sel = {point_count_reg[6:0], 1'b0};
            end else begin
                tx_sel = rd_pos[0] ? rd_val_reg[7:0] : rd_val_reg[15:8];
            end
        end else begin
            case (tx_idx_reg)
                6'd2:    tx_sel = start_address_reg[15:8];
                6'd3:    tx_sel = start_address_reg[7:0];
                6'd4:    tx_sel = (fc_reg == FC_WRITE_SINGLE) ? write_value_reg[15:8]
                                                              : point_count_reg[15:8];
                default: tx_sel = (fc_reg == FC_WRITE_SINGLE) ? write_value_reg[7:0]
                                                              : point_count_reg[7:0];
            endcase
        end
    end

    always_comb begin
        parse_next           = parse_reg;
        seq_next             = seq_reg;
        slave_id_next        = slave_id_reg;
        reg_base_next        = reg_base_reg;
        fc_next              = fc_reg;
        start_address_next   = start_address_reg;
        current_address_next = current_address_reg;
        point_count_next     = point_count_reg;
        points_left_next     = points_left_reg;
        crc_hi_next          = crc_hi_reg;
        write_value_next     = write_value_reg;
        staged_valid_next    = staged_valid_reg;
        store_valid_next     = store_valid_reg;
        cm_idx_next          = cm_idx_reg;
        tx_idx_next          = tx_idx_reg;
        rd_val_next          = rd_val_reg;
        m_valid_next         = m_valid_reg && !m_tready;
        m_data_next          = m_data_reg;
        m_last_next          = m_last_reg;
        crc_cmd              = '0;
        crc_cmd.data         = s_tdata;
        store_we             = 1'b0;
        store_waddr          = cur_idx;
        store_wdata          = write_value_reg;
        store_raddr          = rd_idx;
        stage_we             = 1'b0;
        stage_waddr          = cur_idx;
        stage_wdata          = {write_value_reg[15:8], s_tdata};
        stage_raddr          = cm_idx_reg;

        if (cfg_wr) begin
            if (paddr[2] == ADDR_SLAVE_ID) begin
                slave_id_next = pwdata[7:0];
            end else begin
                reg_base_next = pwdata[15:0];
            end
        end

        unique case (seq_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (parse_reg)
                        P_ID: begin
                            if (s_tdata == slave_id_reg) begin
                                staged_valid_next = '0;
                                crc_cmd.start     = 1'b1;
                                crc_cmd.init      = 1'b1;
                                parse_next        = P_FUNC;
                                seq_next          = S_CRC_WAIT;
                            end
                        end
                        P_FUNC: begin
                            if (fc_ok) begin
                                fc_next       = s_tdata;
                                crc_cmd.start = 1'b1;
                                parse_next    = P_ADDR_H;
                                seq_next      = S_CRC_WAIT;
                            end else begin
                                parse_next = P_ID;
                            end
                        end
                        P_ADDR_H: begin
                            start_address_next = {s_tdata, 8'h00};
                            crc_cmd.start      = 1'b1;
                            parse_next         = P_ADDR_L;
                            seq_next           = S_CRC_WAIT;
                        end
                        P_ADDR_L: begin
                            start_address_next   = {start_address_reg[15:8], s_tdata};
                            current_address_next = {start_address_reg[15:8], s_tdata};
                            crc_cmd.start        = 1'b1;
                            seq_next             = S_CRC_WAIT;
                            if (fc_reg == FC_WRITE_SINGLE) begin
                                point_count_next = 16'd1;
                                points_left_next = 5'd1;
                                parse_next       = P_DATA_H;
                            end else begin
                                parse_next = P_CNT_H;
                            end
                        end
                        P_CNT_H: begin
                            point_count_next = {s_tdata, 8'h00};
                            crc_cmd.start    = 1'b1;
                            parse_next       = P_CNT_L;
                            seq_next         = S_CRC_WAIT;
                        end
                        P_CNT_L: begin
                            point_count_next = {point_count_reg[15:8], s_tdata};
                            points_left_next = s_tdata[4:0];
                            crc_cmd.start    = 1'b1;
                            seq_next         = S_CRC_WAIT;
                            if (({point_count_reg[15:8], s_tdata} == 16'd0) ||
                                ({point_count_reg[15:8], s_tdata} > 16'(MAX_COUNT))) begin
                                parse_next = P_ID;
                            end else if (fc_reg == FC_WRITE_MULTI) begin
                                parse_next = P_BYTECNT;
                            end else begin
                                parse_next = P_CRC_H;
                            end
                        end
                        P_BYTECNT: begin
                            crc_cmd.start = 1'b1;
                            parse_next    = P_DATA_H;
                            seq_next      = S_CRC_WAIT;
                        end
                        P_DATA_H: begin
                            write_value_next = {s_tdata, 8'h00};
                            crc_cmd.start    = 1'b1;
                            parse_next       = P_DATA_L;
                            seq_next         = S_CRC_WAIT;
                        end
                        P_DATA_L: begin
                            write_value_next = {write_value_reg[15:8], s_tdata};
                            points_left_next = points_left_reg - 5'd1;
                            crc_cmd.start    = 1'b1;
                            seq_next         = S_CRC_WAIT;
                            if (points_left_reg == 5'd1) begin
                                parse_next = P_CRC_H;
                            end else begin
                                stage_we             = cur_map;
                                if (cur_map) begin
                                    staged_valid_next[cur_idx] = 1'b1;
                                end
                                current_address_next = current_address_reg + 16'd1;
                                parse_next           = P_DATA_H;
                            end
                        end
                        P_CRC_H: begin
                            crc_hi_next = s_tdata;
                            parse_next  = P_CRC_L;
                        end
                        P_CRC_L: begin
                            parse_next = P_ID;
                            if ({crc_stat.crc[7:0], crc_stat.crc[15:8]} ==
                                {crc_hi_reg, s_tdata}) begin
                                tx_idx_next = 6'd0;
                                cm_idx_next = '0;
                                if (fc_reg == FC_WRITE_MULTI) begin
                                    seq_next = S_COMMIT_RD;
                                end else if (fc_reg == FC_WRITE_SINGLE) begin
                                    seq_next = S_LASTWR;
                                end else begin
                                    staged_valid_next = '0;
                                    seq_next          = S_TX_NEXT;
                                end
                            end else begin
                                staged_valid_next = '0;
                            end
                        end
                        default: parse_next = P_ID;
                    endcase
                end
            end
            S_CRC_WAIT: begin
                if (!crc_stat.busy) begin
                    seq_next = S_IDLE;
                end
            end
            S_COMMIT_RD: begin
                if (staged_valid_reg[cm_idx_reg]) begin
                    seq_next = S_COMMIT_WR;
                end else if (cm_idx_reg == IDX_W'(REG_COUNT - 1)) begin
                    seq_next = S_LASTWR;
                end else begin
                    cm_idx_next = cm_idx_reg + IDX_W'(1);
                end
            end
            S_COMMIT_WR: begin
                store_we                     = 1'b1;
                store_waddr                  = cm_idx_reg;
                store_wdata                  = stage_q;
                store_valid_next[cm_idx_reg] = 1'b1;
                if (cm_idx_reg == IDX_W'(REG_COUNT - 1)) begin
                    seq_next = S_LASTWR;
                end else begin
                    cm_idx_next = cm_idx_reg + IDX_W'(1);
                    seq_next    = S_COMMIT_RD;
                end
            end
            S_LASTWR: begin
                store_we = cur_map;
                if (cur_map) begin
                    store_valid_next[cur_idx] = 1'b1;
                end
                staged_valid_next = '0;
                tx_idx_next       = 6'd0;
                seq_next          = S_TX_NEXT;
            end
            S_TX_NEXT: begin
                if (!tx_is_crc && is_rd && (tx_idx_reg >= 6'd3) && !rd_pos[0]) begin
                    seq_next = S_RD_ISSUE;
                end else begin
                    seq_next = S_TX_EMIT;
                end
            end
            S_RD_ISSUE: begin
                seq_next = S_RD_DATA;
            end
            S_RD_DATA: begin
                rd_val_next = (rd_map && store_valid_reg[rd_idx]) ? store_q : 16'h0000;
                seq_next    = S_TX_EMIT;
            end
            S_TX_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tx_sel;
                    m_last_next  = tx_is_end;
                    if (tx_is_end) begin
                        seq_next = S_IDLE;
                    end else if (tx_is_crc) begin
                        tx_idx_next = tx_idx_reg + 6'd1;
                        seq_next    = S_TX_NEXT;
                    end else begin
                        crc_cmd.start = 1'b1;
                        crc_cmd.init  = (tx_idx_reg == 6'd0);
                        crc_cmd.data  = tx_sel;
                        seq_next      = S_TX_CRC;
                    end
                end
            end
            S_TX_CRC: begin
                if (!crc_stat.busy) begin
                    tx_idx_next = tx_idx_reg + 6'd1;
                    seq_next    = S_TX_NEXT;
                end
            end
            default: seq_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_reg           <= P_ID;
            seq_reg             <= S_IDLE;
            slave_id_reg        <= 8'd1;
            reg_base_reg        <= 16'd0;
            fc_reg              <= 8'd0;
            start_address_reg   <= 16'd0;
            current_address_reg <= 16'd0;
            point_count_reg     <= 16'd0;
            points_left_reg     <= 5'd0;
            crc_hi_reg          <= 8'd0;
            write_value_reg     <= 16'd0;
            staged_valid_reg    <= '0;
            store_valid_reg     <= '0;
            cm_idx_reg          <= '0;
            tx_idx_reg          <= 6'd0;
            m_valid_reg         <= 1'b0;
            m_last_reg          <= 1'b0;
        end else begin
            parse_reg           <= parse_next;
            seq_reg             <= seq_next;
            slave_id_reg        <= slave_id_next;
            reg_base_reg        <= reg_base_next;
            fc_reg              <= fc_next;
            start_address_reg   <= start_address_next;
            current_address_reg <= current_address_next;
            point_count_reg     <= point_count_next;
            points_left_reg     <= points_left_next;
            crc_hi_reg          <= crc_hi_next;
            write_value_reg     <= write_value_next;
            staged_valid_reg    <= staged_valid_next;
            store_valid_reg     <= store_valid_next;
            cm_idx_reg          <= cm_idx_next;
            tx_idx_reg          <= tx_idx_next;
            m_valid_reg         <= m_valid_next;
            m_last_reg          <= m_last_next;
        end
        rd_val_reg <= rd_val_next;
        m_data_reg <= m_data_next;
    end
endmodule

// ===== rtl/mbrtu_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module mbrtu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/mbrtu_crc.sv =====
// Bit-serial CRC-16/MODBUS unit, one bit per cycle, shared by receive and reply.
// Depends on mbrtu_pkg.
module mbrtu_crc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mbrtu_pkg::crc_cmd_t   cmd_i,
    output mbrtu_pkg::crc_stat_t  stat_o
);
    import mbrtu_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] base;

    always_comb begin
        base     = cmd_i.init ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (cmd_i.start) begin
            crc_next = base ^ {8'h00, cmd_i.data};
            cnt_next = 4'd8;
        end else if (cnt_reg != 4'd0) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            cnt_reg <= 4'd0;
        end else begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign stat_o.busy = (cnt_reg != 4'd0);
    assign stat_o.crc  = crc_reg;
endmodule

// ===== rtl/mbrtu_checker.sv =====
// Port-level checker of the Modbus RTU slave frame engine, bound to the top level.
// Depends on modbus_rtu_slave_frame_engine_defines.svh.
`include "modbus_rtu_slave_frame_engine_defines.svh"

module mbrtu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    `MBRTU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `MBRTU_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `MBRTU_ASSERT_SAME(a_busy_in_reply, aclk, aresetn, m_tvalid && !m_tlast, !s_tready)
    `MBRTU_ASSERT_SAME(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_tvalid)
endmodule

bind modbus_rtu_slave_frame_engine mbrtu_checker u_mbrtu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/tb.sv =====
// Testbench for the Modbus RTU slave frame engine: request bytes are streamed in and
// every reply byte is checked against a behavioural model kept inside the bench.
// Depends on mbrtu_pkg and modbus_rtu_slave_frame_engine.
`timescale 1ns / 1ps

module tb;
    import mbrtu_pkg::*;

    typedef enum logic [3:0] {
        P_ID, P_FUNC, P_ADDR_H, P_ADDR_L, P_CNT_H, P_CNT_L, P_CRC_H, P_CRC_L,
        P_BYTECNT, P_DATA_H, P_DATA_L
    } parse_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_t;

    localparam int WATCHDOG = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_slave_frame_engine dut (.*);

    // Model state.
    logic [7:0]  m_id;
    logic [15:0] m_base;
    parse_t      m_state;
    logic [15:0] m_crc;
    logic [7:0]  m_fc;
    logic [15:0] m_start;
    logic [15:0] m_cur;
    logic [15:0] m_count;
    logic [15:0] m_left;
    logic [15:0] m_rxcrc;
    logic [15:0] m_value;
    logic [15:0] m_staged [REG_COUNT];
    logic        m_svalid [REG_COUNT];
    logic [15:0] m_store [REG_COUNT];

    reply_t      reply_q [$];
    logic [7:0]  byte_q [$];
    int          errors;
    int          replies_seen;
    int          frames_sent;
    int          idle_cycles;
    bit          timed_out;

    function automatic logic [15:0] crc16(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] frame_crc(logic [7:0] f [$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (f[k]) c = crc16(c, f[k]);
        return c;
    endfunction

    function automatic bit to_index(logic [15:0] a, output int idx);
        logic [15:0] d;
        d = a - m_base;
        idx = d;
        return d < REG_COUNT;
    endfunction

    task automatic emit(inout logic [15:0] c, input logic [7:0] b);
        reply_q.push_back('{data: b, last: 1'b0});
        c = crc16(c, b);
    endtask

    task automatic predict_byte(logic [7:0] b);
        logic [15:0] c;
        logic [15:0] v;
        int idx;
        c = CRC_INIT;
        case (m_state)
            P_ID: if (b == m_id) begin
                foreach (m_svalid[k]) m_svalid[k] = 1'b0;
                m_crc = crc16(CRC_INIT, b);
                m_state = P_FUNC;
            end
            P_FUNC: begin
                if (b == FC_READ_HOLDING || b == FC_READ_INPUT || b == FC_WRITE_SINGLE ||
                        b == FC_WRITE_MULTI) begin
                    m_fc = b;
                    m_crc = crc16(m_crc, b);
                    m_state = P_ADDR_H;
                end else begin
                    m_state = P_ID;
                end
            end
            P_ADDR_H: begin
                m_start = {b, 8'h00};
                m_crc = crc16(m_crc, b);
                m_state = P_ADDR_L;
            end
            P_ADDR_L: begin
                m_start = {m_start[15:8], b};
                m_cur = m_start;
                m_crc = crc16(m_crc, b);
                if (m_fc == FC_WRITE_SINGLE) begin
                    m_count = 1;
                    m_left = 1;
                    m_state = P_DATA_H;
                end else begin
                    m_state = P_CNT_H;
                end
            end
            P_CNT_H: begin
                m_count = {b, 8'h00};
                m_crc = crc16(m_crc, b);
                m_state = P_CNT_L;
            end
            P_CNT_L: begin
                m_count = {m_count[15:8], b};
                m_left = m_count;
                m_crc = crc16(m_crc, b);
                if (m_count == 0 || m_count > MAX_COUNT) m_state = P_ID;
                else if (m_fc == FC_WRITE_MULTI) m_state = P_BYTECNT;
                else m_state = P_CRC_H;
            end
            P_BYTECNT: begin
                m_crc = crc16(m_crc, b);
                m_state = P_DATA_H;
            end
            P_DATA_H: begin
                m_value = {b, 8'h00};
                m_crc = crc16(m_crc, b);
                m_state = P_DATA_L;
            end
            P_DATA_L: begin
                m_value = {m_value[15:8], b};
                m_crc = crc16(m_crc, b);
                m_left = m_left - 1;
                if (m_left == 0) begin
                    m_state = P_CRC_H;
                end else begin
                    if (to_index(m_cur, idx)) begin
                        m_staged[idx] = m_value;
                        m_svalid[idx] = 1'b1;
                    end
                    m_cur = m_cur + 1;
                    m_state = P_DATA_H;
                end
            end
            P_CRC_H: begin
                m_rxcrc = {b, 8'h00};
                m_state = P_CRC_L;
            end
            P_CRC_L: begin
                m_rxcrc = {m_rxcrc[15:8], b};
                if ({m_crc[7:0], m_crc[15:8]} == m_rxcrc) begin
                    emit(c, m_id);
                    emit(c, m_fc);
                    if (m_fc == FC_READ_HOLDING || m_fc == FC_READ_INPUT) begin
                        emit(c, 8'(m_count * 2));
                        for (int k = 0; k < m_count && k < MAX_COUNT; k++) begin
                            v = to_index(m_start + 16'(k), idx) ? m_store[idx] : 16'h0000;
                            emit(c, v[15:8]);
                            emit(c, v[7:0]);
                        end
                    end else begin
                        if (m_fc == FC_WRITE_MULTI)
                            for (int k = 0; k < REG_COUNT; k++)
                                if (m_svalid[k]) m_store[k] = m_staged[k];
                        if (to_index(m_cur, idx)) m_store[idx] = m_value;
                        emit(c, m_start[15:8]);
                        emit(c, m_start[7:0]);
                        if (m_fc == FC_WRITE_SINGLE) begin
                            emit(c, m_value[15:8]);
                            emit(c, m_value[7:0]);
                        end else begin
                            emit(c, m_count[15:8]);
                            emit(c, m_count[7:0]);
                        end
                    end
                    reply_q.push_back('{data: c[7:0], last: 1'b0});
                    reply_q.push_back('{data: c[15:8], last: 1'b1});
                end
                foreach (m_svalid[k]) m_svalid[k] = 1'b0;
                m_state = P_ID;
            end
            default: m_state = P_ID;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Request frame builder: appends the CRC, optionally corrupted.
    task automatic queue_frame(logic [7:0] f [$], bit corrupt);
        logic [15:0] c;
        c = frame_crc(f);
        if (corrupt) c = c ^ 16'(1 << $urandom_range(15, 0));
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[k]) byte_q.push_back(f[k]);
        frames_sent++;
    endtask

    task automatic random_frame();
        logic [7:0] f [$];
        logic [15:0] a;
        logic [15:0] n;
        int pick;
        pick = $urandom_range(9, 0);
        a = ($urandom_range(3, 0) == 0) ? 16'($urandom) :
            16'(m_base + 16'($urandom_range(40, 0)) - 16'd4);
        f.push_back(($urandom_range(15, 0) == 0) ? 8'($urandom) : m_id);
        if (pick < 3) begin
            n = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(31, 0)) :
                16'($urandom_range(6, 1));
            f.push_back(pick == 0 ? FC_READ_INPUT : FC_READ_HOLDING);
            f.push_back(a[15:8]); f.push_back(a[7:0]);
            f.push_back(n[15:8]); f.push_back(n[7:0]);
        end else if (pick < 6) begin
            f.push_back(FC_WRITE_SINGLE);
            f.push_back(a[15:8]); f.push_back(a[7:0]);
            f.push_back(8'($urandom)); f.push_back(8'($urandom));
        end else if (pick < 9) begin
            n = 16'($urandom_range(5, 1));
            f.push_back(FC_WRITE_MULTI);
            f.push_back(a[15:8]); f.push_back(a[7:0]);
            f.push_back(n[15:8]); f.push_back(n[7:0]);
            f.push_back(8'(n * 2));
            for (int k = 0; k < n * 2; k++) f.push_back(8'($urandom));
        end else begin
            for (int k = 0; k < $urandom_range(4, 1); k++) f.push_back(8'($urandom));
        end
        queue_frame(f, $urandom_range(11, 0) == 0);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) m_id = data[7:0];
        else m_base = data[15:0];
    endtask

    // Sends the queued bytes in bursts, predicting each accepted byte.
    task automatic send_bytes();
        int burst;
        while (byte_q.size() > 0 && !timed_out) begin
            burst = $urandom_range(12, 1);
            while (burst > 0 && byte_q.size() > 0 && !timed_out) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_q[0];
                @(posedge aclk);
                if (s_tready) begin
                    predict_byte(byte_q.pop_front());
                    burst--;
                end
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(2, 0) == 0 ? 0 : $urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (reply_q.size() > 0 && !timed_out) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (reply_q.size() == 0) begin
                    report_mismatch("unexpected reply byte", m_tdata, 0);
                end else begin
                    if (m_tdata !== reply_q[0].data)
                        report_mismatch("tx_byte", m_tdata, reply_q[0].data);
                    if (m_tlast !== reply_q[0].last)
                        report_mismatch("tx_last", m_tlast, reply_q[0].last);
                    void'(reply_q.pop_front());
                end
            end
            m_tready <= ($urandom_range(7, 0) < 5) || (replies_seen % 128 < 20);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d reply bytes outstanding", reply_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    typedef struct {
        logic [7:0] bytes [$];
        bit         corrupt;
    } frame_row_t;

    initial begin
        frame_row_t rows [$];
        errors = 0; replies_seen = 0; frames_sent = 0; idle_cycles = 0; timed_out = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_id = 8'd1; m_base = 16'd0; m_state = P_ID; m_crc = CRC_INIT; m_fc = '0;
        m_start = '0; m_cur = '0; m_count = '0; m_left = '0; m_rxcrc = '0; m_value = '0;
        foreach (m_store[k]) begin
            m_store[k] = '0; m_staged[k] = '0; m_svalid[k] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: reset reads, writes, wrap, unmapped, bad codes, counts, bad CRC.
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h1D}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_WRITE_SINGLE, 8'h00, 8'h00, 8'hFF, 8'hFF}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_WRITE_SINGLE, 8'h00, 8'h1F, 8'h00, 8'h00}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_WRITE_SINGLE, 8'hFF, 8'hFF, 8'h12, 8'h34}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_WRITE_MULTI, 8'hFF, 8'hFF, 8'h00, 8'h03, 8'h06,
                                  8'hAA, 8'h55, 8'h01, 8'h02, 8'h80, 8'h7F}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_WRITE_MULTI, 8'h00, 8'h04, 8'h00, 8'h02, 8'h04,
                                  8'h11, 8'h22, 8'h33, 8'h44}, corrupt: 1});
        rows.push_back('{bytes: '{8'd1, FC_READ_INPUT, 8'hFF, 8'hFE, 8'h00, 8'h06}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h00}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h1E}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'hFF, 8'hFF}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, 8'h07, 8'h00}, corrupt: 0});
        rows.push_back('{bytes: '{8'd9, FC_READ_HOLDING}, corrupt: 0});
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h01}, corrupt: 1});
        rows.push_back('{bytes: '{8'd1, FC_READ_HOLDING, 8'h00, 8'h00, 8'h00, 8'h1D}, corrupt: 0});
        foreach (rows[r]) queue_frame(rows[r].bytes, rows[r].corrupt);
        send_bytes();
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin apb_write(3'd0, 32'd255); apb_write(3'd4, 32'd65535); end
                1: begin apb_write(3'd0, 32'd0);   apb_write(3'd4, 32'd0); end
                2: begin apb_write(3'd0, 32'($urandom_range(254, 1)));
                         apb_write(3'd4, 32'($urandom_range(65535, 0))); end
                3: begin apb_write(3'd0, 32'd1);   apb_write(3'd4, 32'd65520); end
                default: begin apb_write(3'd0, 32'($urandom)); apb_write(3'd4, 32'd100); end
            endcase
            for (int k = 0; k < 8; k++) random_frame();
            send_bytes();
            drain();
        end

        $display("%0d request frames sent, %0d reply bytes checked, %0d mismatches",
                 frames_sent, replies_seen, errors);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
